/* rtl/core/rsma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsma_pkg
// Widths and sequencer states for the rational sum and minimum accumulator.
// ---------------------------------------------------------------------------
package rsma_pkg;
	localparam int ITEM_BITS = 16;
	localparam int SUM_BITS  = 32;
	localparam int WIDE_BITS = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_ADD,
		ST_GCD,
		ST_DIV_N,
		ST_DIV_D,
		ST_CHECK,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

/* rtl/core/rational_sum_and_min_accumulator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rational_sum_and_min_accumulator_core
// Running rational sum in lowest terms plus the minimum fraction seen.
// ---------------------------------------------------------------------------
// The Euclid step count sets how long one input word takes. The
// cross-multiply runs through ST_MUL1, ST_MUL2 and ST_MUL3 on one shared
// multiplier, and ST_ADD then sets up the sign and the magnitude. A shared
// 64-bit restoring divider then runs one quotient bit per cycle, and it
// also does each Euclid remainder step. There is at least one step and up
// to about seventy, and the operand values set the count. When the
// remainder reaches zero, the divider is loaded for the reduction. The
// numerator and then the denominator are divided by the GCD in ST_DIV_N and
// ST_DIV_D, and ST_CHECK follows. While the sticky overflow holds the sum
// and first is low, the result word is offered in the cycle after the
// accept. in_stall stays high until the result word is taken, and the next
// word can be accepted in the cycle after that. The minimum compare is done
// in the accept cycle.
module rational_sum_and_min_accumulator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [rsma_pkg::ITEM_BITS-1:0]   frac_num,
	input  wire logic [rsma_pkg::ITEM_BITS-2:0]          frac_den,
	input  wire logic                            first,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [rsma_pkg::SUM_BITS-1:0]         sum_num,
	output logic [rsma_pkg::SUM_BITS-2:0]                sum_den,
	output logic signed [rsma_pkg::ITEM_BITS-1:0]        min_num,
	output logic [rsma_pkg::ITEM_BITS-2:0]               min_den,
	output logic                                 overflow
);
	import rsma_pkg::*;

	localparam int CW = $clog2(WIDE_BITS + 1);

	state_t state_q, state_d;
	logic signed [SUM_BITS-1:0]  acc_num_q;
	logic [SUM_BITS-2:0]         acc_den_q;
	logic signed [ITEM_BITS-1:0] least_num_q;
	logic [ITEM_BITS-2:0]        least_den_q;
	logic                        ovf_q;
	logic signed [ITEM_BITS-1:0] sn_q;
	logic [ITEM_BITS-2:0]        fd_q;
	logic [WIDE_BITS-1:0]        p_q, t_q, rd_q, mag_q;
	logic                        neg_q;
	// divider
	logic [WIDE_BITS-1:0]        dvd_q, dvs_q, quo_q, rem_q;
	logic [CW-1:0]               cnt_q;
	logic [WIDE_BITS-1:0]        gx_q, gy_q;

	// shared multiplier operands
	logic signed [SUM_BITS:0]    ma, mb;
	logic signed [2*SUM_BITS+1:0] mprod;
	logic [WIDE_BITS:0]          rem_sh;
	logic                        div_done;
	logic                        in_acc, out_acc;
	logic [ITEM_BITS-2:0]        fd_in;
	logic signed [SUM_BITS-1:0]  cmp_l, cmp_r;
	logic                        take_min;
	logic                        bad;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign fd_in   = (frac_den == '0) ? {{(ITEM_BITS-2){1'b0}}, 1'b1} : frac_den;

	// exact compare against the stored minimum, both denominators positive
	assign cmp_l = SUM_BITS'(frac_num) * SUM_BITS'(signed'({1'b0, least_den_q}));
	assign cmp_r = SUM_BITS'(least_num_q) * SUM_BITS'(signed'({1'b0, fd_in}));
	assign take_min = first || (cmp_l < cmp_r);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_MUL1: begin
				ma = (SUM_BITS+1)'(acc_num_q);
				mb = (SUM_BITS+1)'(signed'({1'b0, fd_q}));
			end
			ST_MUL2: begin
				ma = (SUM_BITS+1)'(sn_q);
				mb = (SUM_BITS+1)'(signed'({1'b0, acc_den_q}));
			end
			ST_MUL3: begin
				ma = (SUM_BITS+1)'(signed'({1'b0, acc_den_q}));
				mb = (SUM_BITS+1)'(signed'({1'b0, fd_q}));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mprod = (2*SUM_BITS+2)'(ma) * (2*SUM_BITS+2)'(mb);

	assign rem_sh   = {rem_q, dvd_q[WIDE_BITS-1]};
	assign div_done = (cnt_q == CW'(WIDE_BITS));

	// mag_q holds the reduced magnitude, quo_q the reduced denominator
	always_comb begin
		bad = (neg_q ? (mag_q > (64'd1 << (SUM_BITS-1))) :
			(mag_q > ((64'd1 << (SUM_BITS-1)) - 64'd1))) ||
			(quo_q > ((64'd1 << (SUM_BITS-1)) - 64'd1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_d = ovf_q && !first ? ST_OUT : ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_ADD;
			ST_ADD:   state_d = ST_GCD;
			ST_GCD:   if (gy_q == '0) state_d = ST_DIV_N;
			ST_DIV_N: if (div_done) state_d = ST_DIV_D;
			ST_DIV_D: if (div_done) state_d = ST_CHECK;
			ST_CHECK: state_d = ST_OUT;
			ST_OUT:   if (out_acc) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	assign sum_num  = acc_num_q;
	assign sum_den  = acc_den_q;
	assign min_num  = least_num_q;
	assign min_den  = least_den_q;
	assign overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_num_q   <= '0;
			acc_den_q   <= {{(SUM_BITS-2){1'b0}}, 1'b1};
			least_num_q <= '0;
			least_den_q <= {{(ITEM_BITS-2){1'b0}}, 1'b1};
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sn_q <= frac_num;
						fd_q <= fd_in;
						if (first) begin
							acc_num_q <= '0;
							acc_den_q <= {{(SUM_BITS-2){1'b0}}, 1'b1};
							ovf_q     <= 1'b0;
						end
						if (take_min) begin
							least_num_q <= frac_num;
							least_den_q <= fd_in;
						end
					end
				end
				ST_MUL1: p_q <= WIDE_BITS'(mprod);
				ST_MUL2: t_q <= p_q + WIDE_BITS'(mprod);
				ST_MUL3: rd_q <= WIDE_BITS'(mprod);
				ST_ADD: begin
					neg_q <= t_q[WIDE_BITS-1];
					mag_q <= t_q[WIDE_BITS-1] ? (64'd0 - t_q) : t_q;
					gx_q  <= t_q[WIDE_BITS-1] ? (64'd0 - t_q) : t_q;
					gy_q  <= rd_q;
					cnt_q <= '0;
					rem_q <= '0;
					dvd_q <= t_q[WIDE_BITS-1] ? (64'd0 - t_q) : t_q;
					dvs_q <= rd_q;
				end
				ST_GCD: begin
					// one remainder bit per cycle, then rotate x <- y, y <- r
					if (gy_q != '0) begin
						if (div_done) begin
							gx_q  <= gy_q;
							gy_q  <= rem_q;
							dvd_q <= gy_q;
							dvs_q <= rem_q;
							rem_q <= '0;
							cnt_q <= '0;
						end else begin
							dvd_q <= {dvd_q[WIDE_BITS-2:0], 1'b0};
							if (rem_sh >= {1'b0, dvs_q})
								rem_q <= WIDE_BITS'(rem_sh - {1'b0, dvs_q});
							else
								rem_q <= rem_sh[WIDE_BITS-1:0];
							cnt_q <= cnt_q + CW'(1);
						end
					end else begin
						// divide magnitude by gcd (gcd 0 means 1)
						dvd_q <= mag_q;
						dvs_q <= (gx_q == '0) ? 64'd1 : gx_q;
						rem_q <= '0;
						cnt_q <= '0;
					end
				end
				ST_DIV_N, ST_DIV_D: begin
					if (div_done) begin
						if (state_q == ST_DIV_N) begin
							mag_q <= quo_q;
							dvd_q <= rd_q;
							rem_q <= '0;
							cnt_q <= '0;
						end
					end else begin
						dvd_q <= {dvd_q[WIDE_BITS-2:0], 1'b0};
						if (rem_sh >= {1'b0, dvs_q}) begin
							rem_q <= WIDE_BITS'(rem_sh - {1'b0, dvs_q});
							quo_q <= {quo_q[WIDE_BITS-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[WIDE_BITS-1:0];
							quo_q <= {quo_q[WIDE_BITS-2:0], 1'b0};
						end
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_CHECK: begin
					// hold the sum and raise the sticky flag when out of range
					if (bad) begin
						ovf_q <= 1'b1;
					end else begin
						acc_num_q <= SUM_BITS'(neg_q ? (64'd0 - mag_q) : mag_q);
						acc_den_q <= (quo_q == '0) ? {{(SUM_BITS-2){1'b0}}, 1'b1} :
							quo_q[SUM_BITS-2:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(sum_num) && $stable(sum_den)))
		else $error("result changed while stalled");
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sum_den != '0))
		else $error("zero sum denominator");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q && !(in_acc && first)) |=> ovf_q)
		else $error("overflow flag dropped");
endmodule
`default_nettype wire
